// ----- hw/rtl/huffman_table_bit_decoder_top_macros.svh -----
// assertion macros for the huffman bit decoder
// used by modules that check their own control logic; needs clk and rst_n in scope
`ifndef HUFFMAN_TABLE_BIT_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TABLE_BIT_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbd check failed");
`define HBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbd check failed");
`else
`define HBD_ASSERT_IMP(lbl, ante, cons)
`define HBD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/hbd_pkg.sv -----
// shared types and constants for the huffman bit decoder
// no dependencies
package hbd_pkg;

    localparam int HBD_TABLE_DEPTH  = 256;
    localparam int HBD_MAX_CODE_LEN = 32;
    localparam int HBD_CODE_W       = 32;
    localparam int HBD_LEN_W        = 6;
    localparam int HBD_SYM_W        = 8;
    localparam int HBD_ENTRY_W      = HBD_CODE_W + HBD_LEN_W + HBD_SYM_W;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_BIT   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEARED  = 3'd0,
        ST_LOADED   = 3'd1,
        ST_PENDING  = 3'd2,
        ST_SYMBOL   = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADLEN   = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_LOAD   = 3'd1,
        K_BADLEN = 3'd2,
        K_BIT    = 3'd3,
        K_NOP    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [HBD_LEN_W-1:0]  len;
        logic [HBD_SYM_W-1:0]  sym;
        logic [HBD_CODE_W-1:0] code;
        logic                  dbit;
    } cmd_t;

endpackage

// ----- hw/rtl/hbd_ifs.sv -----
// request and response channel interfaces
// depends on nothing
interface hbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  entry_length;
    logic [7:0]  entry_symbol;
    logic [31:0] entry_code;
    logic        data_bit;
    modport source (output valid, req_type, entry_length, entry_symbol, entry_code, data_bit,
                    input ready);
    modport sink (input valid, req_type, entry_length, entry_symbol, entry_code, data_bit,
                  output ready);
endinterface

interface hbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [2:0] status;
    logic [5:0] pending_bits;
    modport source (output valid, symbol, status, pending_bits, input ready);
    modport sink (input valid, symbol, status, pending_bits, output ready);
endinterface

// ----- hw/rtl/hbd_ram.sv -----
// generic single write, single read ram with registered read
// no dependencies
module hbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

// ----- hw/rtl/hbd_front.sv -----
// front end: takes request beats, classifies them and queues them
// depends on hbd_pkg and hbd_ifs
module hbd_front
    import hbd_pkg::*;
#(
    parameter int MAX_CODE_LEN = HBD_MAX_CODE_LEN
) (
    input  logic      clk,
    input  logic      rst_n,
    hbd_req_if.sink   req,
    output cmd_t      head,
    output logic      head_valid,
    input  logic      head_pop
);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < HBD_CODE_W) ? MAX_CODE_LEN : HBD_CODE_W;

    cmd_t                  cmd_in;
    logic [HBD_CODE_W-1:0] mask;
    logic                  push;
    cmd_t                  mem_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            cnt_reg, cnt_next;

    always_comb
    begin
        cmd_in.len  = req.entry_length[HBD_LEN_W-1:0];
        cmd_in.sym  = req.entry_symbol;
        cmd_in.dbit = req.data_bit;
        mask        = {HBD_CODE_W{1'b1}} >> (HBD_LEN_W'(HBD_CODE_W) - cmd_in.len);
        cmd_in.code = req.entry_code & mask;
        case (req.req_type)
            REQ_CLEAR: cmd_in.kind = K_CLEAR;
            REQ_LOAD:
            begin
                if (req.entry_length == 8'd0 || req.entry_length > 8'(LEN_LIMIT))
                begin
                    cmd_in.kind = K_BADLEN;
                end
                else
                begin
                    cmd_in.kind = K_LOAD;
                end
            end
            REQ_BIT:   cmd_in.kind = K_BIT;
            default:   cmd_in.kind = K_NOP;
        endcase
    end

    assign req.ready  = (cnt_reg != 2'd2);
    assign push       = req.valid && req.ready;
    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = head_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(head_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

// ----- hw/rtl/hbd_back.sv -----
// back end: table scan, pending code and result register
// depends on hbd_pkg, hbd_ifs, hbd_ram and the macro header
`include "huffman_table_bit_decoder_top_macros.svh"
module hbd_back
    import hbd_pkg::*;
#(
    parameter int TABLE_DEPTH  = HBD_TABLE_DEPTH,
    parameter int MAX_CODE_LEN = HBD_MAX_CODE_LEN
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  logic      head_valid,
    output logic      head_pop,
    hbd_rsp_if.source rsp
);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < HBD_CODE_W) ? MAX_CODE_LEN : HBD_CODE_W;
    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_m1;
    logic [HBD_CODE_W-1:0] pend_code_reg, pend_code_next;
    logic [HBD_LEN_W-1:0]  pend_len_reg, pend_len_next;
    kind_t                 wkind_reg, wkind_next;
    logic [HBD_CODE_W-1:0] wcode_reg, wcode_next;
    logic [HBD_LEN_W-1:0]  wlen_reg, wlen_next;
    logic [HBD_SYM_W-1:0]  wsym_reg, wsym_next;
    logic                  out_valid_reg, out_valid_next;
    logic [HBD_SYM_W-1:0]  out_sym_reg, out_sym_next;
    status_t               out_status_reg, out_status_next;
    logic [HBD_LEN_W-1:0]  out_pend_reg, out_pend_next;

    logic [HBD_CODE_W-1:0]  key_code, cur_code;
    logic [HBD_LEN_W-1:0]   key_len, cur_len;
    kind_t                  cur_kind;
    logic [HBD_SYM_W-1:0]   cur_sym;
    logic                   out_free, finish, found, match;
    logic                   rd_en, we;
    logic [ADDR_W-1:0]      rd_addr, waddr;
    logic [HBD_ENTRY_W-1:0] wdata, rdata;

    hbd_ram #(.WIDTH(HBD_ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign match    = (rdata[HBD_SYM_W +: HBD_LEN_W] == wlen_reg)
                   && (rdata[HBD_ENTRY_W-1 -: HBD_CODE_W] == wcode_reg);

    always_comb
    begin
        if (head.kind == K_BIT)
        begin
            key_code = {pend_code_reg[HBD_CODE_W-2:0], head.dbit};
            key_len  = pend_len_reg + HBD_LEN_W'(1);
        end
        else
        begin
            key_code = head.code;
            key_len  = head.len;
        end
        if (state_reg == S_IDLE)
        begin
            cur_kind = head.kind;
            cur_code = key_code;
            cur_len  = key_len;
            cur_sym  = head.sym;
        end
        else
        begin
            cur_kind = wkind_reg;
            cur_code = wcode_reg;
            cur_len  = wlen_reg;
            cur_sym  = wsym_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_code_next  = pend_code_reg;
        pend_len_next   = pend_len_reg;
        wkind_next      = wkind_reg;
        wcode_next      = wcode_reg;
        wlen_next       = wlen_reg;
        wsym_next       = wsym_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_sym_next    = out_sym_reg;
        out_status_next = out_status_reg;
        out_pend_next   = out_pend_reg;
        head_pop        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg - ADDR_W'(1);
        we              = 1'b0;
        waddr           = cnt_reg[ADDR_W-1:0];
        wdata           = {cur_code, cur_len, cur_sym};
        finish          = 1'b0;
        found           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if ((head.kind == K_LOAD || head.kind == K_BIT) && cnt_reg != '0)
                    begin
                        head_pop   = 1'b1;
                        wkind_next = head.kind;
                        wcode_next = key_code;
                        wlen_next  = key_len;
                        wsym_next  = head.sym;
                        rd_en      = 1'b1;
                        rd_addr    = cnt_m1[ADDR_W-1:0];
                        idx_next   = cnt_m1[ADDR_W-1:0];
                        state_next = S_SCAN;
                    end
                    else if (out_free)
                    begin
                        head_pop = 1'b1;
                        finish   = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (match || idx_reg == '0)
                begin
                    if (out_free)
                    begin
                        finish     = 1'b1;
                        found      = match;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg - ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            out_valid_next  = 1'b1;
            out_sym_next    = '0;
            out_status_next = ST_PENDING;
            case (cur_kind)
                K_CLEAR:
                begin
                    cnt_next        = '0;
                    pend_code_next  = '0;
                    pend_len_next   = '0;
                    out_status_next = ST_CLEARED;
                end
                K_LOAD:
                begin
                    if (found)
                    begin
                        we              = 1'b1;
                        waddr           = idx_reg;
                        out_status_next = ST_LOADED;
                    end
                    else if (cnt_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        we              = 1'b1;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        out_status_next = ST_LOADED;
                    end
                end
                K_BADLEN:
                begin
                    out_status_next = ST_BADLEN;
                end
                K_BIT:
                begin
                    if (found)
                    begin
                        out_sym_next    = rdata[HBD_SYM_W-1:0];
                        out_status_next = ST_SYMBOL;
                        pend_code_next  = '0;
                        pend_len_next   = '0;
                    end
                    else if (cur_len >= HBD_LEN_W'(LEN_LIMIT))
                    begin
                        out_status_next = ST_OVERFLOW;
                        pend_code_next  = '0;
                        pend_len_next   = '0;
                    end
                    else
                    begin
                        pend_code_next = cur_code;
                        pend_len_next  = cur_len;
                    end
                end
                default:
                begin
                    out_status_next = ST_PENDING;
                end
            endcase
            out_pend_next = pend_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wkind_reg   <= wkind_next;
        wcode_reg   <= wcode_next;
        wlen_reg    <= wlen_next;
        wsym_reg    <= wsym_next;
        idx_reg     <= idx_next;
        out_sym_reg <= out_sym_next;
        out_pend_reg <= out_pend_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_code_reg <= '0;
            pend_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_code_reg <= pend_code_next;
            pend_len_reg  <= pend_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.symbol       = out_sym_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.pending_bits = out_pend_reg;

    `HBD_ASSERT_IMP(a_scan_has_entries, state_reg == S_SCAN, cnt_reg != '0)
    `HBD_ASSERT_IMP(a_pend_below_limit, state_reg == S_IDLE, pend_len_reg < HBD_LEN_W'(LEN_LIMIT))
    `HBD_ASSERT_NXT(a_hit_gives_symbol, finish && found && cur_kind == K_BIT, out_valid_reg && out_status_reg == ST_SYMBOL && pend_len_reg == '0)
    `HBD_ASSERT_IMP(a_count_in_range, 1'b1, cnt_reg <= CNT_W'(TABLE_DEPTH))
endmodule

// ----- hw/rtl/huffman_table_bit_decoder_top.sv -----
// huffman table bit decoder: top level
// depends on hbd_pkg, hbd_ifs, hbd_ram, hbd_front and hbd_back
//
// usage:
//   req channel: one beat per request; req_type selects clear table,
//   load one entry (entry_code/entry_length/entry_symbol) or one coded
//   bit (data_bit). a beat is taken when valid and ready are both high
//   rsp channel: exactly one beat per request, in request order, with
//   symbol (nonzero only on a decode hit), status and pending_bits
//   clear, bad length and unused requests, and loads and bits while the
//   table is empty, go from the queue head straight to the response
//   register; other loads and bits scan the table one entry per cycle
//   from newest to oldest; the scan stops at the first hit
//   the back end takes a new request only once the last one is through
//   its scan, since the table ram has a single read port
//   a two-entry queue sits between the classifying front end and the
//   scanning back end, so requests keep flowing while a result waits
//   reset: table empty, no pending code, queue and response register
//   empty; table ram contents are left as they are and never read
//   when rsp is stalled the finished result is held and the back end
//   waits; the front end keeps filling its queue until it is full
module huffman_table_bit_decoder_top
    import hbd_pkg::*;
#(
    parameter int TABLE_DEPTH  = HBD_TABLE_DEPTH,
    parameter int MAX_CODE_LEN = HBD_MAX_CODE_LEN
) (
    input  logic      clk,
    input  logic      rst_n,
    hbd_req_if.sink   req,
    hbd_rsp_if.source rsp
);
    // classified request at the head of the queue
    cmd_t head;
    logic head_valid;
    logic head_pop;

    hbd_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    hbd_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .rsp        (rsp)
    );
endmodule

// ----- sim/hbd_tb_ifs.sv -----
`timescale 1ns / 1ps
// channel interfaces for the testbench build come from hw/rtl/hbd_ifs.sv
// this file holds no declarations so both builds share one definition

// ----- sim/huffman_table_bit_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// testbench for huffman_table_bit_decoder_top: table loads, clears and coded bits
// depends on hbd_pkg, the channel interfaces and the block's rtl
module huffman_table_bit_decoder_top_tb;
    import hbd_pkg::*;

    localparam int DEPTH   = HBD_TABLE_DEPTH;
    localparam int LEN_MAX = (HBD_MAX_CODE_LEN < 32) ? HBD_MAX_CODE_LEN : 32;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        status_t    status;
        logic [5:0] pending_bits;
    } decode_result_t;

    // decoder model plus expected result queue
    class decode_scoreboard;
        logic [31:0]    tab_code [DEPTH];
        logic [5:0]     tab_len  [DEPTH];
        logic [7:0]     tab_sym  [DEPTH];
        int             n_entries;
        logic [31:0]    pend_code;
        int             pend_len;
        decode_result_t expected_q[$];
        int             mismatches;

        function new();
            n_entries  = 0;
            pend_code  = '0;
            pend_len   = 0;
            mismatches = 0;
        endfunction

        // newest matching slot, or -1
        function int lookup(logic [31:0] code, int len);
            for (int i = n_entries - 1; i >= 0; i--)
                if (tab_len[i] == len && tab_code[i] == code)
                    return i;
            return -1;
        endfunction

        function void note_request(logic [1:0] rt, logic [7:0] len, logic [7:0] sym,
                                   logic [31:0] code, logic dbit);
            decode_result_t r;
            logic [31:0]    mask;
            int             slot;
            r.symbol = '0;
            r.status = ST_PENDING;
            if (rt == REQ_CLEAR)
            begin
                n_entries = 0;
                pend_code = '0;
                pend_len  = 0;
                r.status  = ST_CLEARED;
            end
            else if (rt == REQ_LOAD)
            begin
                if (len == 0 || len > LEN_MAX)
                begin
                    r.status = ST_BADLEN;
                end
                else
                begin
                    mask = (len >= 32) ? '1 : ((32'd1 << len) - 1);
                    code = code & mask;
                    slot = lookup(code, int'(len));
                    if (slot >= 0)
                    begin
                        tab_sym[slot] = sym;
                        r.status = ST_LOADED;
                    end
                    else if (n_entries >= DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        tab_code[n_entries] = code;
                        tab_len[n_entries]  = len[5:0];
                        tab_sym[n_entries]  = sym;
                        n_entries++;
                        r.status = ST_LOADED;
                    end
                end
            end
            else if (rt == REQ_BIT)
            begin
                pend_code = {pend_code[30:0], dbit};
                pend_len++;
                mask = (pend_len >= 32) ? '1 : ((32'd1 << pend_len) - 1);
                slot = lookup(pend_code & mask, pend_len);
                if (slot >= 0)
                begin
                    r.symbol  = tab_sym[slot];
                    r.status  = ST_SYMBOL;
                    pend_code = '0;
                    pend_len  = 0;
                end
                else if (pend_len >= LEN_MAX)
                begin
                    r.status  = ST_OVERFLOW;
                    pend_code = '0;
                    pend_len  = 0;
                end
            end
            r.pending_bits = pend_len[5:0];
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(logic [7:0] sym, logic [2:0] st, logic [5:0] pb);
            decode_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: sym %0d status %0d pend %0d",
                             sym, st, pb);
                return;
            end
            e = expected_q.pop_front();
            if (e.symbol !== sym || e.status !== st || e.pending_bits !== pb)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp sym %0d st %0d pend %0d, ",
                              "got sym %0d st %0d pend %0d"},
                             e.symbol, e.status, e.pending_bits, sym, st, pb);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    hbd_req_if req ();
    hbd_rsp_if rsp ();

    huffman_table_bit_decoder_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    decode_scoreboard sb;
    int   cycle_count = 0;
    int   sent_count  = 0;
    bit   long_hold;      // set by stimulus to ask for a long receiver stall
    bit   long_hold_done;

    // per-loaded-code bookkeeping so the stimulus can send well-formed codes
    logic [31:0] gen_code [$];
    int          gen_len  [$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // monitor: acceptances at each rising edge feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                sb.note_request(req.req_type, req.entry_length, req.entry_symbol,
                                req.entry_code, req.data_bit);
            if (rsp.valid && rsp.ready)
                sb.check_result(rsp.symbol, rsp.status, rsp.pending_bits);
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        int hold;
        rsp.ready <= 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold && !long_hold_done)
            begin
                // long stall so the queue fills and req.ready drops
                rsp.ready <= 1'b0;
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if ((cycle_count / 500) % 3 == 0)
            begin
                rsp.ready <= 1'b1;  // stretches with no stall
            end
            else
            begin
                rsp.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000)
        begin
            $display("huffman_table_bit_decoder_top_tb: done, errors");
            $finish;
        end
    end

    // sender state for bursts and gaps
    int burst_left;

    // drive one beat and hold it until taken; gaps between bursts
    task automatic send_beat(logic [1:0] rt, logic [7:0] len, logic [7:0] sym,
                             logic [31:0] code, logic dbit);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        req.valid        <= 1'b1;
        req.req_type     <= rt;
        req.entry_length <= len;
        req.entry_symbol <= sym;
        req.entry_code   <= code;
        req.data_bit     <= dbit;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic send_clear();
        send_beat(REQ_CLEAR, 8'($urandom), 8'($urandom), $urandom, 1'($urandom));
        gen_code.delete();
        gen_len.delete();
    endtask

    task automatic send_load(logic [7:0] len, logic [7:0] sym, logic [31:0] code);
        send_beat(REQ_LOAD, len, sym, code, 1'($urandom));
        if (len != 0 && len <= LEN_MAX && gen_code.size() < DEPTH)
        begin
            gen_code.insert(gen_code.size(), code);
            gen_len.insert(gen_len.size(), int'(len));
        end
    endtask

    task automatic send_bit(logic b);
        send_beat(REQ_BIT, 8'($urandom), 8'($urandom), $urandom, b);
    endtask

    // stream one code first bit first
    task automatic send_code(logic [31:0] code, int len);
        for (int i = len - 1; i >= 0; i--)
            send_bit(code[i]);
    endtask

    // random table: random codes of small lengths
    task automatic load_random_table(int n, int maxlen);
        int l;
        for (int i = 0; i < n; i++)
        begin
            l = $urandom_range(1, maxlen);
            send_load(8'(l), 8'($urandom), $urandom);
        end
    endtask

    initial
    begin
        int sel;
        int k;
        sb = new();
        burst_left  = 0;
        long_hold   = 1'b0;
        rst_n = 1'b0;
        req.valid        <= 1'b0;
        req.req_type     <= REQ_CLEAR;
        req.entry_length <= '0;
        req.entry_symbol <= '0;
        req.entry_code   <= '0;
        req.data_bit     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: bad lengths, duplicate, extremes, overflow, unused request
        send_load(8'd0, 8'hAA, 32'h1);           // zero length
        send_load(8'd33, 8'hAA, 32'h1);          // over limit
        send_load(8'd255, 8'hFF, '1);            // widest length field
        send_load(8'd32, 8'hFF, 32'hFFFF_FFFF);  // full-width code
        send_load(8'd2, 8'h11, 32'hFFFF_FFFE);   // upper bits ignored -> code 10
        send_load(8'd2, 8'h22, 32'h2);           // duplicate, overwrites symbol
        send_load(8'd1, 8'h00, 32'h0);           // code 0
        send_code(32'h2, 2);                     // symbol 0x22
        send_bit(1'b0);                          // symbol 0x00
        send_beat(REQ_UNUSED, 8'($urandom), 8'($urandom), $urandom, 1'b1);
        send_bit(1'b1);                          // pending in middle of code
        send_load(8'd3, 8'h33, 32'h7);           // load during a code
        send_bit(1'b1);                          // hits 11? no: pending 2
        send_code(32'hFFFF_FFFF, 30);            // all ones: repeated hits on code 111 (0x33)
        send_clear();
        repeat (32) send_bit(1'b1);              // empty table: overflow
        send_clear();
        // fill to full, then full rejection and duplicate on full table
        for (k = 0; k < DEPTH; k++)
            send_load(8'd16, k[7:0], 32'h1000 + k);
        send_load(8'd16, 8'h5A, 32'h9999);       // table full
        send_load(8'd16, 8'hA5, 32'h1000);       // duplicate still accepted
        send_code(32'h1000, 16);
        send_code(32'h10FF, 16);
        send_clear();

        // random: well-formed streams against random tables, plus noise
        while (sent_count < 1150)
        begin
            sel = $urandom_range(0, 99);
            if (sent_count > 500 && !long_hold)
            begin
                long_hold = 1'b1;
            end
            if (sel < 4)
            begin
                send_clear();
                load_random_table($urandom_range(1, 12), $urandom_range(2, 8));
            end
            else if (sel < 8)
            begin
                send_load(8'($urandom_range(0, 40)), 8'($urandom), $urandom);
            end
            else if (sel < 10)
            begin
                send_beat(REQ_UNUSED, 8'($urandom), 8'($urandom), $urandom,
                          1'($urandom));
            end
            else if (sel < 14)
            begin
                send_bit(1'($urandom));
            end
            else if (sel < 16)
            begin
                // long codes
                send_load(8'($urandom_range(1, 32)), 8'($urandom), $urandom);
            end
            else if (gen_code.size() != 0)
            begin
                int idx;
                idx = $urandom_range(0, gen_code.size() - 1);
                send_code(gen_code[idx], gen_len[idx]);
            end
            else
            begin
                load_random_table($urandom_range(1, 12), $urandom_range(2, 8));
            end
        end
        req.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DEPTH + 20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("huffman_table_bit_decoder_top_tb: done, clean");
        else
            $display("huffman_table_bit_decoder_top_tb: done, errors");
        $finish;
    end
endmodule
